>>> hdl/spfr_pkg.sv
// Shared types and constants for the sensor poll frame receiver.
// Depends on nothing; imported by sensor_poll_frame_receiver, spfr_poll_checker and the testbench.
package spfr_pkg;

  localparam int BUFFER_DEPTH = 20;  // bytes counted per reply, 10..31
  localparam int FRAME_BYTES  = 10;  // length of a valid measurement frame, 7..20

  localparam logic [31:0] PERIOD_RST  = 32'd10000;
  localparam logic [15:0] FIRST_RST   = 16'd1000;
  localparam logic [15:0] GAP_RST     = 16'd50;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_FIRST  = 2'd1;
  localparam logic [1:0] REG_GAP    = 2'd2;

  // input beat kind
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // phase of a result record; TX phases 0..2, close event at 3
  localparam logic [1:0] PH_FIRST_TX = 2'd0;
  localparam logic [1:0] PH_LAST_TX  = 2'd2;
  localparam logic [1:0] PH_CLOSE    = 2'd3;

  typedef enum logic [1:0] {
    EV_TX      = 2'd0,
    EV_MEAS    = 2'd1,
    EV_BADLEN  = 2'd2,
    EV_NOREPLY = 2'd3
  } spfr_event_t;

  // results caused by one input beat
  typedef struct packed {
    logic        req;     // three command bytes
    logic        cls;     // one frame close event
    spfr_event_t cls_ev;
    logic [31:0] dose;
    logic [4:0]  len;
  } spfr_rec_t;

  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h55;
      2'd1:    b = 8'hAA;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/sensor_poll_frame_receiver.sv
// Top level: sensor poll frame receiver, stream in/out plus APB-style config; uses spfr_pkg.
// An accepted beat's first result beat is registered and shown in the cycle after it when both result
//   slots are empty; a beat parked in the spare slot waits until the active record drains.
// Takes one input beat per cycle while the spare result slot is empty; a beat yields 0..4 result
//   beats, sent one per cycle while out_tready is high, through the single output port.
// Reset (synchronous, rst_n low): timers, byte count and wait flag to zero, regs to defaults.
module sensor_poll_frame_receiver
  import spfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] tx_byte, [39:8] dose_hundredths, [44:40] frame_length
  output logic [1:0]  out_tuser,  // [1:0] event_res
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------------------------------------------------------- config
  logic [31:0] period_r;
  logic [15:0] first_to_r;
  logic [15:0] gap_to_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= PERIOD_RST;
      first_to_r <= FIRST_RST;
      gap_to_r   <= GAP_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_PERIOD: period_r   <= cfg_pwdata;
        REG_FIRST:  first_to_r <= cfg_pwdata[15:0];
        REG_GAP:    gap_to_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_PERIOD: cfg_prdata = period_r;
      REG_FIRST:  cfg_prdata = {16'd0, first_to_r};
      REG_GAP:    cfg_prdata = {16'd0, gap_to_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- poll state
  logic [31:0] time_r, time_nxt;
  logic [31:0] req_time_r, req_time_nxt;
  logic [31:0] lbt_r, lbt_nxt;            // last byte time stamp
  logic [4:0]  bc_r, bc_nxt;              // byte count
  logic        wait_r, wait_nxt;          // waiting for reply
  logic [7:0]  vb_r [4];                  // frame bytes 3..6
  logic [7:0]  vb_nxt [4];
  spfr_rec_t   rec;
  logic        in_acc;
  logic [1:0]  vidx;

  assign in_acc = in_tvalid & in_tready;
  assign vidx   = 2'(bc_r - 5'd3);

  // One beat's whole step: tick/byte handling, then the close check.
  always_comb begin
    time_nxt     = time_r;
    req_time_nxt = req_time_r;
    lbt_nxt      = lbt_r;
    bc_nxt       = bc_r;
    wait_nxt     = wait_r;
    for (int i = 0; i < 4; i++) vb_nxt[i] = vb_r[i];
    rec          = '0;
    rec.cls_ev   = EV_TX;

    if (in_tuser == OP_TICK) begin
      time_nxt = time_r + 32'd1;
      if ((time_nxt - req_time_r) >= period_r) begin
        req_time_nxt = time_nxt;
        bc_nxt       = 5'd0;
        wait_nxt     = 1'b1;
        lbt_nxt      = 32'd0;
        rec.req      = 1'b1;
      end
    end else begin
      if (bc_r < 5'(BUFFER_DEPTH)) begin
        if (bc_r >= 5'd3 && bc_r <= 5'd6) vb_nxt[vidx] = in_tdata;
        bc_nxt = bc_r + 5'd1;
      end
      lbt_nxt = time_r;  // stamped even when the buffer is full
    end

    if (wait_nxt) begin
      if (bc_nxt == 5'd0) begin
        if ((time_nxt - req_time_nxt) >= {16'd0, first_to_r}) begin
          rec.cls    = 1'b1;
          rec.cls_ev = EV_NOREPLY;
          wait_nxt   = 1'b0;
        end
      end else if ((time_nxt - lbt_nxt) >= {16'd0, gap_to_r}) begin
        rec.cls = 1'b1;
        rec.len = bc_nxt;
        if (bc_nxt == 5'(FRAME_BYTES)) begin
          rec.cls_ev = EV_MEAS;
          rec.dose   = {vb_nxt[3], vb_nxt[2], vb_nxt[1], vb_nxt[0]};
        end else begin
          rec.cls_ev = EV_BADLEN;
        end
        bc_nxt   = 5'd0;
        wait_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r     <= 32'd0;
      req_time_r <= 32'd0;
      lbt_r      <= 32'd0;
      bc_r       <= 5'd0;
      wait_r     <= 1'b0;
      for (int i = 0; i < 4; i++) vb_r[i] <= 8'd0;
    end else if (in_acc) begin
      time_r     <= time_nxt;
      req_time_r <= req_time_nxt;
      lbt_r      <= lbt_nxt;
      bc_r       <= bc_nxt;
      wait_r     <= wait_nxt;
      for (int i = 0; i < 4; i++) vb_r[i] <= vb_nxt[i];
    end
  end

  // ---------------------------------------------------------------- result buffer
  // cur: record being sent, ph_r = phase of the beat on the port.
  // nxt: spare slot, filled while cur is still draining.
  spfr_rec_t  cur_r, nxt_r;
  logic       cur_vld_r, nxt_vld_r;
  logic [1:0] ph_r;
  logic [1:0] ph_end;
  logic [1:0] ph_start_new, ph_start_nxt;
  logic       has_res;
  logic       beat_out;
  logic       cur_done;
  logic       cur_free;

  assign has_res      = rec.req | rec.cls;
  assign ph_end       = cur_r.cls ? PH_CLOSE : PH_LAST_TX;
  assign ph_start_new = rec.req ? PH_FIRST_TX : PH_CLOSE;
  assign ph_start_nxt = nxt_r.req ? PH_FIRST_TX : PH_CLOSE;
  assign beat_out     = out_tvalid & out_tready;
  assign cur_done     = beat_out & (ph_r == ph_end);
  assign cur_free     = ~cur_vld_r | cur_done;
  assign in_tready    = ~nxt_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      nxt_vld_r <= 1'b0;
      ph_r      <= PH_FIRST_TX;
    end else if (cur_free) begin
      if (nxt_vld_r) begin
        cur_r     <= nxt_r;
        cur_vld_r <= 1'b1;
        nxt_vld_r <= 1'b0;
        ph_r      <= ph_start_nxt;
      end else if (in_acc && has_res) begin
        cur_r     <= rec;
        cur_vld_r <= 1'b1;
        ph_r      <= ph_start_new;
      end else begin
        cur_vld_r <= 1'b0;
      end
    end else begin
      if (beat_out) ph_r <= ph_r + 2'd1;
      if (in_acc && has_res) begin
        nxt_r     <= rec;
        nxt_vld_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    out_tvalid = cur_vld_r;
    out_tlast  = (ph_r == ph_end);
    if (ph_r == PH_CLOSE) begin
      out_tuser = cur_r.cls_ev;
      out_tdata = {3'd0, cur_r.len, cur_r.dose, 8'd0};
    end else begin
      out_tuser = EV_TX;
      out_tdata = {3'd0, 5'd0, 32'd0, cmd_byte(ph_r)};
    end
  end

  // ---------------------------------------------------------------- checks
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (ph_r <= ph_end))
    else $error("result phase ran past the record end");

  a_spare_needs_cur: assert property (@(posedge clk) disable iff (!rst_n)
    nxt_vld_r |-> cur_vld_r)
    else $error("spare slot filled while active slot empty");

  a_meas_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == EV_MEAS) |-> (out_tdata[44:40] == 5'(FRAME_BYTES)))
    else $error("measurement with wrong frame length");

  a_close_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && rec.cls) |=> !wait_r && (bc_r == 5'd0))
    else $error("frame close left receiver waiting");

endmodule

>>> verif/spfr_poll_checker.sv
`timescale 1ns / 100ps
// Result checker for the sensor poll frame receiver: tracks register writes,
// predicts the result beats of every accepted input beat and compares them.
// Depends on spfr_pkg.
module spfr_poll_checker
  import spfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // [7:0] tx_byte, [39:8] dose_hundredths, [44:40] frame_length
  input  logic [1:0]  out_tuser,  // [1:0] event_res
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          n_fail,
  output int          n_pending,
  output int          n_checked,
  output int          n_dose
);

  typedef struct packed {
    spfr_event_t ev;
    logic [7:0]  tx;
    logic [31:0] dose;
    logic [4:0]  len;
    logic        last;
  } poll_result_t;

  localparam logic [7:0] POLL_CMD [3] = '{8'h55, 8'hAA, 8'h01};

  // register copies
  logic [31:0] period_ms;
  logic [15:0] first_ms;
  logic [15:0] gap_ms;

  // poller state
  logic [31:0] ms_now;
  logic [31:0] ms_requested;
  logic [31:0] ms_last_rx;
  logic [4:0]  rx_count;
  logic        awaiting;
  logic [7:0]  dose_le [4];

  poll_result_t pending_results [$];
  poll_result_t want;
  poll_result_t got;
  int           fails   = 0;
  int           checked = 0;
  int           doses   = 0;

  function automatic poll_result_t make_result(spfr_event_t ev, logic [7:0] tx,
                                               logic [31:0] dose, logic [4:0] len);
    poll_result_t r;
    r.ev   = ev;
    r.tx   = tx;
    r.dose = dose;
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      fails++;
    end
  endfunction

  // Expected result beats of one tick or one received byte.
  task automatic predict_beat(input logic op, input logic [7:0] rx);
    int           n_before;
    poll_result_t r;
    n_before = pending_results.size();
    if (op == OP_TICK) begin
      ms_now = ms_now + 32'd1;
      if (ms_now - ms_requested >= period_ms) begin
        ms_requested = ms_now;
        rx_count     = '0;
        awaiting     = 1'b1;
        ms_last_rx   = '0;
        for (int i = 0; i < 3; i++)
          pending_results.push_back(make_result(EV_TX, POLL_CMD[i], '0, '0));
      end
    end else begin
      if (rx_count < BUFFER_DEPTH) begin
        if (rx_count >= 5'd3 && rx_count <= 5'd6) dose_le[rx_count - 5'd3] = rx;
        rx_count = rx_count + 5'd1;
      end
      ms_last_rx = ms_now;  // stamped even when the buffer is full
    end
    // frame close, only while a reply is awaited
    if (awaiting) begin
      if (rx_count == '0) begin
        if (ms_now - ms_requested >= first_ms) begin
          pending_results.push_back(make_result(EV_NOREPLY, '0, '0, '0));
          awaiting = 1'b0;
        end
      end else if (ms_now - ms_last_rx >= gap_ms) begin
        if (rx_count == FRAME_BYTES)
          pending_results.push_back(make_result(EV_MEAS, '0,
            {dose_le[3], dose_le[2], dose_le[1], dose_le[0]}, rx_count));
        else
          pending_results.push_back(make_result(EV_BADLEN, '0, '0, rx_count));
        rx_count = '0;
        awaiting = 1'b0;
      end
    end
    if (pending_results.size() > n_before) begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      period_ms    = PERIOD_RST;
      first_ms     = FIRST_RST;
      gap_ms       = GAP_RST;
      ms_now       = '0;
      ms_requested = '0;
      ms_last_rx   = '0;
      rx_count     = '0;
      awaiting     = 1'b0;
      for (int i = 0; i < 4; i++) dose_le[i] = '0;
      pending_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_PERIOD: period_ms = cfg_pwdata;
          REG_FIRST:  first_ms  = cfg_pwdata[15:0];
          REG_GAP:    gap_ms    = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.ev   = spfr_event_t'(out_tuser);
        got.tx   = out_tdata[7:0];
        got.dose = out_tdata[39:8];
        got.len  = out_tdata[44:40];
        got.last = out_tlast;
        if (pending_results.size() == 0) begin
          $display("[%0t] unexpected result: event %0d tx 0x%0h dose 0x%0h len %0d last %0b",
                   $time, got.ev, got.tx, got.dose, got.len, got.last);
          fails++;
        end else begin
          want = pending_results.pop_front();
          field_check("event_res", 32'(want.ev), 32'(got.ev));
          field_check("tx_byte", 32'(want.tx), 32'(got.tx));
          field_check("dose_hundredths", want.dose, got.dose);
          field_check("frame_length", 32'(want.len), 32'(got.len));
          field_check("last", 32'(want.last), 32'(got.last));
          checked++;
          if (want.ev == EV_MEAS) doses++;
        end
      end
      if (in_tvalid && in_tready) predict_beat(in_tuser, in_tdata);
    end
    n_pending <= pending_results.size();
    n_fail    <= fails;
    n_checked <= checked;
    n_dose    <= doses;
  end

endmodule

>>> verif/tb_sensor_poll_frame_receiver.sv
`timescale 1ns / 100ps
// Testbench top for the sensor poll frame receiver: clock, reset, register
// setup, tick/byte stimulus, result back-pressure and the verdict.
// Depends on spfr_pkg, sensor_poll_frame_receiver and spfr_poll_checker.
module tb_sensor_poll_frame_receiver;
  import spfr_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;  // far beyond the slowest legal run
  localparam int HOLD_CYCLES   = 60;      // long receiver stall, fills the result buffer
  localparam int SETTLE_CYCLES = 8;       // covers beats that produce no result

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata  = '0;    // [7:0] rx_byte
  logic        in_tuser  = 1'b0;  // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // [7:0] tx_byte, [39:8] dose_hundredths, [44:40] frame_length
  logic [1:0]  out_tuser;         // [1:0] event_res
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int n_fail, n_pending, n_checked, n_dose;

  // stimulus bookkeeping
  int          send_idle_pct = 0;   // used by the sender itself
  int          rcv_idle_pct  = 0;   // read by the receiver process
  int          hold_tokens   = 0;   // bumped to request one long stall
  int          holds_done    = 0;
  int          n_beats       = 0;
  int          n_bytes       = 0;
  int          n_settings    = 0;
  int          cycle_count;
  logic [31:0] period_now = PERIOD_RST;
  int          first_now  = int'(FIRST_RST);
  int          gap_now    = int'(GAP_RST);
  // ms since the last request, mirrored so polls can be lined up with requests
  logic [31:0] since_req  = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sensor_poll_frame_receiver dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  spfr_poll_checker poll_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .n_fail      (n_fail),
    .n_pending   (n_pending),
    .n_checked   (n_checked),
    .n_dose      (n_dose)
  );

  // Result side. Random stalls per rcv_idle_pct; on request one long hold-off
  // that is counted here, while the sender keeps offering beats.
  always begin
    @(posedge clk);
    if (hold_tokens != holds_done) begin
      out_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      holds_done = holds_done + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog: a hang or a lost result ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run timed out after %0d cycles, %0d results outstanding", cycle_count, n_pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One input beat. tvalid stays high across back-to-back beats and only
  // drops when the sender decides to idle.
  task automatic send_beat(input logic op, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    n_beats++;
    if (op == OP_BYTE) begin
      n_bytes++;
    end else begin
      // same modular test as the block: a request fires once the period has passed
      since_req = since_req + 32'd1;
      if (since_req >= period_now) since_req = '0;
    end
  endtask

  // rx_byte is don't-care on a tick, so it carries noise
  task automatic tick();
    send_beat(OP_TICK, 8'($urandom_range(255)));
  endtask

  // Stop offering, let every expected result drain, then let a beat with no
  // result finish inside the block before anything is reconfigured.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup and access cycle; psel stays up so writes can follow back to back.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic load_regs(input logic [31:0] period, input logic [15:0] first,
                           input logic [15:0] gap);
    cfg_write(REG_PERIOD, period);
    cfg_write(REG_FIRST, {16'h0, first});
    cfg_write(REG_GAP, {16'h0, gap});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    period_now = period;
    first_now  = int'(first);
    gap_now    = int'(gap);
    n_settings++;
  endtask

  // Random phase: mostly well-formed polls (request, reply, close) with random
  // content and timing, plus bad lengths, silent sensors and plain noise.
  task automatic run_phase(input int tx_pct, input int rx_pct, input logic [31:0] period,
                           input logic [15:0] first, input logic [15:0] gap);
    int start_beats;
    int polls;
    int kind;
    int len;
    quiesce();
    load_regs(period, first, gap);
    send_idle_pct = tx_pct;
    rcv_idle_pct <= rx_pct;
    start_beats = n_beats;
    polls = 0;
    while (n_beats - start_beats < 24 || polls < 2) begin
      // line up with the next request
      do tick(); while (since_req != 0);
      kind = $urandom_range(9);
      if (kind < 6) begin
        len = FRAME_BYTES;
      end else if (kind == 6) begin
        len = $urandom_range(BUFFER_DEPTH + 1, BUFFER_DEPTH + 4);  // overruns the buffer
      end else if (kind == 7) begin
        len = $urandom_range(1, BUFFER_DEPTH);
        if (len == FRAME_BYTES) len = len - 1;
      end else begin
        len = 0;
      end
      if (kind == 9) begin
        repeat ($urandom_range(3, 8)) send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
      end else if (len == 0) begin
        repeat (first_now) tick();  // sensor stays silent
      end else begin
        repeat ($urandom_range(0, first_now - 1)) tick();
        for (int i = 0; i < len; i++) begin
          send_beat(OP_BYTE, 8'($urandom_range(255)));
          if (i < len - 1 && gap_now > 1 && $urandom_range(3) == 0)
            repeat ($urandom_range(1, gap_now - 1)) tick();
        end
        repeat (gap_now) tick();  // idle gap closes the frame
      end
      polls++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // Zero period and zero first-byte timeout: every tick requests and the
    // no-reply event follows at once, four result beats per tick.
    load_regs(32'd0, 16'd0, 16'd0);
    tick();
    send_beat(OP_BYTE, 8'h00);  // not waiting: counted, nothing closes
    tick();                     // request clears that byte
    quiesce();

    // Zero gap: a byte closes the frame on arrival (bad length of one).
    load_regs(32'd1, 16'd5, 16'd0);
    tick();
    send_beat(OP_BYTE, 8'hFF);
    quiesce();

    // Upper extremes: no request ever fires, bytes while idle, silent tick.
    load_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_beat(OP_BYTE, 8'h5A);
    send_beat(OP_BYTE, 8'hA5);
    tick();
    quiesce();

    // Lower extremes on the timeouts: a full frame with an all-ones value,
    // then a silent sensor hitting the one-ms first-byte timeout.
    load_regs(32'd2, 16'd1, 16'd1);
    do tick(); while (since_req != 0);
    for (int i = 0; i < FRAME_BYTES; i++)
      send_beat(OP_BYTE, ((i >= 3 && i <= 6) || i[0]) ? 8'hFF : 8'h00);
    tick();
    tick();
    tick();
    quiesce();

    // ---- back-pressure ----
    // Four results per tick while the receiver holds off: the result buffer
    // fills and the block has to stall its input.
    load_regs(32'd0, 16'd0, 16'd0);
    hold_tokens <= hold_tokens + 1;
    repeat (20) tick();

    // ---- random ----
    run_phase(35, 53, 32'd4, 16'd2, 16'd1);
    run_phase(53, 35, 32'd8, 16'd3, 16'd2);
    run_phase(0, 0, 32'd6, 16'd2, 16'd1);
    quiesce();

    $display("Covered %0d input beats (%0d serial bytes) over %0d register settings;",
             n_beats, n_bytes, n_settings);
    $display("checked %0d result beats, %0d of them dose readings.", n_checked, n_dose);
    if (n_fail == 0 && n_pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
hdl/spfr_pkg.sv
hdl/sensor_poll_frame_receiver.sv
verif/spfr_poll_checker.sv
verif/tb_sensor_poll_frame_receiver.sv
